// ===== rtl/core/asc_pkg.sv =====
// shared types and constants for the calibrated converter scan block
`timescale 1ns / 1ps

package asc_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned VALUE_W   = 11;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FULL_SCALE = 1000;
  // numerator of the mapping is FULL_SCALE times a 10-bit difference
  localparam int unsigned DIV_BITS   = 20;

  localparam logic [SAMPLE_W-1:0] CAL_MIN_RST = 10'd0;
  localparam logic [SAMPLE_W-1:0] CAL_MID_RST = 10'd511;
  localparam logic [SAMPLE_W-1:0] CAL_MAX_RST = 10'd1023;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_CONV  = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    PH_IDLE    = 2'd0,
    PH_WORKING = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN = 2'd0,
    CFG_MID = 2'd1,
    CFG_MAX = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] cmin;
    logic [SAMPLE_W-1:0] cmid;
    logic [SAMPLE_W-1:0] cmax;
  } cal_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] sample;
  } map_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [VALUE_W-1:0] value;
  } map_rsp_t;

endpackage

// ===== rtl/core/asc_ram.sv =====
// generic single-port ram with registered read
`timescale 1ns / 1ps

module asc_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/asc_map.sv =====
// three-point calibration mapping with a restoring serial divider
`timescale 1ns / 1ps

module asc_map import asc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cal_t     cal_i,
  input  map_req_t req_i,
  output map_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIV_BITS);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_DIV  = 4'b0100,
    M_FIN  = 4'b1000
  } map_state_e;

  map_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] diff_q, diff_d;
  logic [SAMPLE_W-1:0] div_q, div_d;
  logic                above_q, above_d;
  logic                neg_q, neg_d;
  logic                eq_q, eq_d;
  logic                zero_q, zero_d;
  logic [DIV_BITS-1:0] num_q, num_d;
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic signed [SAMPLE_W:0] span;
  logic [SAMPLE_W:0]        span_abs;
  logic [SAMPLE_W:0]        trial;
  logic                     trial_ge;
  logic [SAMPLE_W-1:0]      mag;
  logic signed [VALUE_W-1:0] value;

  // prep: which side of mid, and signed span of that side
  always_comb begin
    above_d = req_i.sample > cal_i.cmid;
    eq_d    = req_i.sample == cal_i.cmid;
    if (above_d) begin
      diff_d = req_i.sample - cal_i.cmid;
      span   = $signed({1'b0, cal_i.cmax}) - $signed({1'b0, cal_i.cmid});
    end else begin
      diff_d = cal_i.cmid - req_i.sample;
      span   = $signed({1'b0, cal_i.cmid}) - $signed({1'b0, cal_i.cmin});
    end
    span_abs = span[SAMPLE_W] ? (~span + 1'b1) : span;
    div_d    = span_abs[SAMPLE_W-1:0];
    zero_d   = span == '0;
    // negative quotient when exactly one of difference direction and span is negative
    neg_d    = ~above_d ^ span[SAMPLE_W];
  end

  assign trial    = {rem_q, num_q[DIV_BITS-1]};
  assign trial_ge = trial >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          state_d = M_MUL;
        end
      end
      M_MUL: begin
        num_d   = DIV_BITS'(diff_q) * DIV_BITS'(FULL_SCALE);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = M_DIV;
      end
      M_DIV: begin
        rem_d = trial_ge ? SAMPLE_W'(trial - {1'b0, div_q}) : trial[SAMPLE_W-1:0];
        num_d = {num_q[DIV_BITS-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
          state_d = M_FIN;
        end
      end
      M_FIN: begin
        state_d = M_IDLE;
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  // saturate the quotient, apply the sign; mid maps to zero, a zero span to full scale
  always_comb begin
    mag = (num_q > DIV_BITS'(FULL_SCALE)) ? SAMPLE_W'(FULL_SCALE) : num_q[SAMPLE_W-1:0];
    if (eq_q) begin
      value = '0;
    end else if (zero_q) begin
      value = above_q ? VALUE_W'(FULL_SCALE) : -VALUE_W'(FULL_SCALE);
    end else if (neg_q) begin
      value = -$signed({1'b0, mag});
    end else begin
      value = $signed({1'b0, mag});
    end
  end

  assign rsp_o.done  = state_q == M_FIN;
  assign rsp_o.value = value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && req_i.start) begin
      diff_q  <= diff_d;
      div_q   <= div_d;
      above_q <= above_d;
      neg_q   <= neg_d;
      eq_q    <= eq_d;
      zero_q  <= zero_d;
    end
    num_q <= num_d;
    rem_q <= rem_d;
  end

endmodule

// ===== rtl/core/adc_scan_calibrated_mapper_core.sv =====
// top level: scan sequencing, sample memory, calibration registers, result register
`timescale 1ns / 1ps

// Scans NUM_CHANNELS converter channels and maps a stored 10-bit sample onto
// -1000..1000 through one shared min/mid/max calibration. Items are taken one
// at a time: a start or conversion-complete beat goes from accept straight to
// the result hand-off, while a read passes through a sample memory read, a
// prep, a multiply, the serial divider, a finish and the result hand-off, its
// time set mostly by the one-bit-per-cycle divider. A new beat may be
// accepted while the previous result still sits in the output register. The
// sample memory needs no clearing pass: per-channel valid bits cleared at
// reset make unwritten channels read as zero. Calibration writes are taken at
// any time but belong between beats.
module adc_scan_calibrated_mapper_core import asc_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ACTION_W-1:0]        action_i,
  input  logic [SAMPLE_W-1:0]        sample_i,
  input  logic [CHAN_W-1:0]          channel_index_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [STATUS_W-1:0]        scan_status_o,
  output logic [CHAN_W-1:0]          next_channel_o,
  output logic                       scan_complete_o,
  output logic signed [VALUE_W-1:0]  mapped_value_o
);

  localparam int unsigned PW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_READ = 4'b0010,
    T_MAP  = 4'b0100,
    T_PUSH = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  cal_t cal_q;

  phase_e            phase_q, phase_d;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic [NUM_CHANNELS-1:0] valid_q, valid_d;
  logic              rd_ok_q, rd_ok_d;

  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic [CHAN_W-1:0]         res_chan_q, res_chan_d;
  logic                      res_complete_q, res_complete_d;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;

  logic                      out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]       out_status_q;
  logic [CHAN_W-1:0]         out_chan_q;
  logic                      out_complete_q;
  logic signed [VALUE_W-1:0] out_value_q;

  logic                in_accept;
  logic                chan_ok;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic                out_load;
  logic [PW-1:0]       ptr_inc;
  map_req_t            map_req;
  map_rsp_t            map_rsp;

  assign in_stall_o = state_q != T_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign chan_ok    = {1'b0, channel_index_i} < (CHAN_W + 1)'(NUM_CHANNELS);
  assign ptr_inc    = ptr_q + 1'b1;
  assign out_load   = (state_q == T_PUSH) && (!out_valid_q || !out_stall_i);

  // calibration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.cmin <= CAL_MIN_RST;
      cal_q.cmid <= CAL_MID_RST;
      cal_q.cmax <= CAL_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN: cal_q.cmin <= cfg_data_i;
        CFG_MID: cal_q.cmid <= cfg_data_i;
        CFG_MAX: cal_q.cmax <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    ptr_d          = ptr_q;
    valid_d        = valid_q;
    rd_ok_d        = rd_ok_q;
    res_status_d   = res_status_q;
    res_chan_d     = res_chan_q;
    res_complete_d = res_complete_q;
    res_value_d    = res_value_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_addr       = ptr_q[AW-1:0];
    map_req.start  = 1'b0;
    map_req.sample = rd_ok_q ? ram_rdata : '0;

    case (state_q)
      T_IDLE: begin
        if (in_accept) begin
          res_complete_d = 1'b0;
          res_value_d    = '0;
          state_d        = T_PUSH;
          case (action_e'(action_i))
            ACT_START: begin
              ptr_d   = '0;
              phase_d = PH_WORKING;
            end
            ACT_CONV: begin
              if (phase_q == PH_WORKING) begin
                if (ptr_q < PW'(NUM_CHANNELS)) begin
                  ram_we                   = 1'b1;
                  valid_d[ptr_q[AW-1:0]]   = 1'b1;
                  ptr_d                    = ptr_inc;
                end
                if (ptr_d >= PW'(NUM_CHANNELS)) begin
                  phase_d        = PH_DONE;
                  res_complete_d = 1'b1;
                end
              end
            end
            ACT_READ: begin
              if (chan_ok) begin
                ram_re   = 1'b1;
                ram_addr = channel_index_i[AW-1:0];
                rd_ok_d  = valid_q[channel_index_i[AW-1:0]];
                state_d  = T_READ;
              end
            end
            default: ;
          endcase
          res_status_d = phase_d;
          res_chan_d   = (phase_d == PH_WORKING) ? CHAN_W'(ptr_d) : '0;
        end
      end
      T_READ: begin
        map_req.start = 1'b1;
        state_d       = T_MAP;
      end
      T_MAP: begin
        if (map_rsp.done) begin
          res_value_d = map_rsp.value;
          state_d     = T_PUSH;
        end
      end
      T_PUSH: begin
        if (out_load) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      phase_q     <= PH_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q   <= res_status_d;
    res_chan_q     <= res_chan_d;
    res_complete_q <= res_complete_d;
    res_value_q    <= res_value_d;
    if (out_load) begin
      out_status_q   <= res_status_q;
      out_chan_q     <= res_chan_q;
      out_complete_q <= res_complete_q;
      out_value_q    <= res_value_q;
    end
  end

  asc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (sample_i),
    .rdata_o (ram_rdata)
  );

  asc_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cal_i  (cal_q),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  assign out_valid_o     = out_valid_q;
  assign scan_status_o   = out_status_q;
  assign next_channel_o  = out_chan_q;
  assign scan_complete_o = out_complete_q;
  assign mapped_value_o  = out_value_q;

`ifndef NO_ASSERTIONS
  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WORKING) |-> (ptr_q < PW'(NUM_CHANNELS)))
    else $error("scan pointer past last channel while working");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ptr_q < PW'(NUM_CHANNELS)))
    else $error("sample write beyond channel count");

  a_map_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_rsp.done |-> (state_q == T_MAP))
    else $error("mapping finished outside the mapping state");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mapped_value_o <= $signed(VALUE_W'(FULL_SCALE))
                     && mapped_value_o >= -$signed(VALUE_W'(FULL_SCALE))))
    else $error("mapped value out of full scale");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("second beat accepted while one is in flight");
`endif

endmodule

// ===== bench/adc_scan_calibrated_mapper_checker.sv =====
// checker for the calibrated converter scan block: tracks scan state, predicts and compares
`timescale 1ns / 1ps

module adc_scan_calibrated_mapper_checker import asc_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [SAMPLE_W-1:0]       cfg_data_i,

  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic [SAMPLE_W-1:0]       sample_i,
  input  logic [CHAN_W-1:0]         channel_index_i,

  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [STATUS_W-1:0]       scan_status_i,
  input  logic [CHAN_W-1:0]         next_channel_i,
  input  logic                      scan_complete_i,
  input  logic signed [VALUE_W-1:0] mapped_value_i,

  output int                        fail_count_o,
  output int                        results_due_o
);

  localparam int FULL = int'(FULL_SCALE);

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [CHAN_W-1:0]         next_chan;
    logic                      complete;
    logic signed [VALUE_W-1:0] value;
  } scan_result_t;

  logic [SAMPLE_W-1:0] cal_lo;
  logic [SAMPLE_W-1:0] cal_center;
  logic [SAMPLE_W-1:0] cal_hi;
  logic [SAMPLE_W-1:0] held_samples [NUM_CHANNELS];
  logic [4:0]          scan_ptr;
  phase_e              scan_phase;
  scan_result_t        results_due [$];
  int                  fails;

  function automatic logic signed [VALUE_W-1:0] calibrate(input logic [SAMPLE_W-1:0] raw);
    int a;
    int m;
    int lo;
    int hi;
    int span;
    int q;
    a  = raw;
    m  = cal_center;
    lo = cal_lo;
    hi = cal_hi;
    if (a == m) return '0;
    if (a > m) begin
      span = hi - m;
      if (span == 0) return VALUE_W'(FULL);
      q = (FULL * (a - m)) / span;
    end else begin
      span = m - lo;
      if (span == 0) return VALUE_W'(-FULL);
      q = -((FULL * (m - a)) / span);
    end
    // reversed ranges give quotients of the wrong sign or size
    if (q > FULL) q = FULL;
    if (q < -FULL) q = -FULL;
    return VALUE_W'(q);
  endfunction

  function automatic scan_result_t predict_scan_step(input logic [ACTION_W-1:0] act,
                                                     input logic [SAMPLE_W-1:0] smp,
                                                     input logic [CHAN_W-1:0]   ch);
    scan_result_t r;
    r.complete = 1'b0;
    r.value    = '0;
    case (act)
      ACT_START: begin
        scan_ptr   = '0;
        scan_phase = PH_WORKING;
      end
      ACT_CONV: begin
        if (scan_phase == PH_WORKING) begin
          if (scan_ptr < NUM_CHANNELS) begin
            held_samples[scan_ptr] = smp;
            scan_ptr = scan_ptr + 5'd1;
          end
          if (scan_ptr >= NUM_CHANNELS) begin
            scan_phase = PH_DONE;
            r.complete = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (ch < NUM_CHANNELS) r.value = calibrate(held_samples[ch]);
      end
      default: ;
    endcase
    r.status    = scan_phase;
    r.next_chan = (scan_phase == PH_WORKING) ? scan_ptr[CHAN_W-1:0] : '0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      cal_lo     = CAL_MIN_RST;
      cal_center = CAL_MID_RST;
      cal_hi     = CAL_MAX_RST;
      for (int k = 0; k < NUM_CHANNELS; k++) held_samples[k] = '0;
      scan_ptr   = '0;
      scan_phase = PH_IDLE;
      results_due.delete();
      fails = 0;
      fail_count_o  <= 0;
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN: cal_lo     = cfg_data_i;
          CFG_MID: cal_center = cfg_data_i;
          CFG_MAX: cal_hi     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(predict_scan_step(action_i, sample_i, channel_index_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat with no result expected");
          fails++;
        end else begin
          want = results_due.pop_front();
          if (scan_status_i !== want.status) begin
            $error("scan_status: expected %0d, got %0d", want.status, scan_status_i);
            fails++;
          end
          if (next_channel_i !== want.next_chan) begin
            $error("next_channel: expected %0d, got %0d", want.next_chan, next_channel_i);
            fails++;
          end
          if (scan_complete_i !== want.complete) begin
            $error("scan_complete: expected %0d, got %0d", want.complete, scan_complete_i);
            fails++;
          end
          if (mapped_value_i !== want.value) begin
            $error("mapped_value: expected %0d, got %0d", want.value, mapped_value_i);
            fails++;
          end
        end
      end
      fail_count_o  <= fails;
      results_due_o <= results_due.size();
    end
  end

endmodule

// ===== bench/adc_scan_calibrated_mapper_core_tb.sv =====
// testbench top for the calibrated converter scan block: clock, reset, stimulus, verdict
`timescale 1ns / 1ps

module adc_scan_calibrated_mapper_core_tb;
  import asc_pkg::*;

  localparam int unsigned NUM_CH = NUM_CHANNELS_DEF;
  // far above the slowest correct run with every read waiting out the longest stall
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = CFG_MIN;
  logic [SAMPLE_W-1:0]       cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [ACTION_W-1:0]       action_i = ACT_START;
  logic [SAMPLE_W-1:0]       sample_i = '0;
  logic [CHAN_W-1:0]         channel_index_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [STATUS_W-1:0]       scan_status_o;
  logic [CHAN_W-1:0]         next_channel_o;
  logic                      scan_complete_o;
  logic signed [VALUE_W-1:0] mapped_value_o;

  int fail_count;
  int results_due;
  int cycle_count;
  logic sender_calm = 1'b0;
  logic recv_calm = 1'b0;
  logic [SAMPLE_W-1:0] cur_min = CAL_MIN_RST;
  logic [SAMPLE_W-1:0] cur_mid = CAL_MID_RST;
  logic [SAMPLE_W-1:0] cur_max = CAL_MAX_RST;

  adc_scan_calibrated_mapper_core #(
    .NUM_CHANNELS(NUM_CH)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .sample_i        (sample_i),
    .channel_index_i (channel_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scan_status_o   (scan_status_o),
    .next_channel_o  (next_channel_o),
    .scan_complete_o (scan_complete_o),
    .mapped_value_o  (mapped_value_o)
  );

  adc_scan_calibrated_mapper_checker #(
    .NUM_CHANNELS(NUM_CH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .sample_i        (sample_i),
    .channel_index_i (channel_index_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .scan_status_i   (scan_status_o),
    .next_channel_i  (next_channel_o),
    .scan_complete_i (scan_complete_o),
    .mapped_value_i  (mapped_value_o),
    .fail_count_o    (fail_count),
    .results_due_o   (results_due)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // samples cluster around the calibration points so the edges get hit
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      v = int'(cur_mid) + $urandom_range(0, 4) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return SAMPLE_W'(v);
    end
    if (r < 32) return cur_min;
    if (r < 39) return cur_max;
    if (r < 44) return cur_mid;
    return SAMPLE_W'($urandom);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    if ($urandom_range(0, 99) < 85) return CHAN_W'($urandom_range(0, NUM_CH - 1));
    return CHAN_W'($urandom);
  endfunction

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  task automatic push_beat(input logic [ACTION_W-1:0] act,
                           input logic [SAMPLE_W-1:0] smp,
                           input logic [CHAN_W-1:0]   ch);
    int gap;
    if (!sender_calm && $urandom_range(0, 79) == 0) wait_idle();
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    sample_i        <= smp;
    channel_index_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
  endtask

  task automatic write_cal(input logic [SAMPLE_W-1:0] lo,
                           input logic [SAMPLE_W-1:0] mid,
                           input logic [SAMPLE_W-1:0] hi);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MIN;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= CFG_MID;
    cfg_data_i  <= mid;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX;
    cfg_data_i  <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_min = lo;
    cur_mid = mid;
    cur_max = hi;
  endtask

  // mostly full scans followed by reads, some cut-short scans, some noise
  task automatic run_phase(input int budget);
    int sent;
    int kind;
    int n;
    logic [ACTION_W-1:0] act;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        push_beat(ACT_START, SAMPLE_W'($urandom), CHAN_W'($urandom));
        for (int i = 0; i < NUM_CH; i++) begin
          push_beat(ACT_CONV, pick_sample(), CHAN_W'($urandom));
        end
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          push_beat(ACT_READ, SAMPLE_W'($urandom), pick_channel());
        end
        sent += 1 + NUM_CH + n;
      end else if (kind < 85) begin
        push_beat(ACT_START, SAMPLE_W'($urandom), CHAN_W'($urandom));
        n = $urandom_range(0, NUM_CH - 1);
        for (int i = 0; i < n; i++) begin
          push_beat(ACT_CONV, pick_sample(), CHAN_W'($urandom));
        end
        sent += 1 + n;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          push_beat(ACT_READ, SAMPLE_W'($urandom), pick_channel());
        end
        sent += n;
      end else begin
        act = ACTION_W'($urandom);
        push_beat(act, SAMPLE_W'($urandom), CHAN_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (recv_calm) begin
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
          out_stall_i <= 1'b1;
          stall_left--;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration, store still all zero
    push_beat(ACT_READ, 10'd0, 4'd0);
    push_beat(ACT_CONV, 10'd1023, 4'd15);       // not scanning: ignored
    push_beat(ACT_SPARE, 10'd1023, 4'd15);
    push_beat(ACT_START, 10'd0, 4'd0);
    push_beat(ACT_CONV, 10'd0, 4'd0);
    push_beat(ACT_CONV, 10'd1023, 4'd0);
    push_beat(ACT_CONV, 10'd511, 4'd0);
    push_beat(ACT_CONV, 10'd512, 4'd0);         // last channel completes the scan
    push_beat(ACT_CONV, 10'd5, 4'd0);           // scan done: ignored
    push_beat(ACT_READ, 10'd0, 4'd0);
    push_beat(ACT_READ, 10'd0, 4'd1);
    push_beat(ACT_READ, 10'd0, 4'd2);
    push_beat(ACT_READ, 10'd0, 4'd3);
    push_beat(ACT_READ, 10'd0, 4'd15);
    push_beat(ACT_READ, 10'd0, 4'd4);
    push_beat(ACT_START, 10'd0, 4'd0);          // restart after done
    push_beat(ACT_CONV, 10'd7, 4'd0);
    push_beat(ACT_START, 10'd0, 4'd0);          // restart mid-scan
    push_beat(ACT_START, 10'd0, 4'd0);
    push_beat(ACT_CONV, 10'd300, 4'd0);
    push_beat(ACT_CONV, 10'd100, 4'd0);
    push_beat(ACT_CONV, 10'd900, 4'd0);
    push_beat(ACT_CONV, 10'd700, 4'd0);
    push_beat(ACT_READ, 10'd0, 4'd1);
    push_beat(ACT_READ, 10'd0, 4'd3);

    run_phase(80);
    write_cal(10'd0, 10'd0, 10'd0);
    run_phase(60);
    write_cal(10'd1023, 10'd1023, 10'd1023);
    run_phase(60);
    // reversed on both sides
    write_cal(10'd1023, 10'd512, 10'd0);
    run_phase(60);
    write_cal(10'd0, 10'd500, 10'd500);
    run_phase(50);
    write_cal(10'd500, 10'd500, 10'd1023);
    run_phase(50);
    write_cal(10'd0, 10'd1023, 10'd1023);
    run_phase(40);
    repeat (4) begin
      write_cal(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      run_phase(60);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/asc_pkg.sv
rtl/core/asc_ram.sv
rtl/core/asc_map.sv
rtl/core/adc_scan_calibrated_mapper_core.sv
bench/adc_scan_calibrated_mapper_checker.sv
bench/adc_scan_calibrated_mapper_core_tb.sv
